[hw/rtl/pal_pkg.sv]
// Package for the positional array list: operation and status codes, controller states,
// and the command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package pal_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_LOCATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Which store entry is read relative to the pointer.
   typedef enum logic [1:0] {
      RD_CUR  = 2'd0,
      RD_PREV = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE    = 4'd0,
      S_DECODE  = 4'd1,
      S_INS_RD  = 4'd2,
      S_INS_WR  = 4'd3,
      S_DEL_RD  = 4'd4,
      S_DEL_CAP = 4'd5,
      S_DEL_MRD = 4'd6,
      S_DEL_MWR = 4'd7,
      S_LOC_RD  = 4'd8,
      S_LOC_CMP = 4'd9,
      S_FINISH  = 4'd10
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       count_clear;
      logic       count_inc;
      logic       count_dec;
      logic       ptr_from_count;
      logic       ptr_from_pos;
      logic       ptr_clear;
      logic       ptr_inc;
      logic       ptr_dec;
      rd_sel_type rd_sel;
      logic       mem_we;
      logic       wr_from_val;
      logic       cap_removed;
      logic       set_status;
      status_type status_code;
      logic       set_index;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   ins_pos_bad;
      logic   empty;
      logic   del_pos_bad;
      logic   ins_ptr_done;
      logic   del_ptr_done;
      logic   scan_done;
      logic   hit;
      logic   rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

[hw/rtl/pal_datapath.sv]
// Datapath of the positional array list: request registers, entry count, pointer,
// the list store memory with a registered read port, and the result register.
// Depends on pal_pkg; driven by pal_ctrl through pal_pkg::dp_cmd_type.
`default_nettype none

module pal_datapath #(
   parameter int CAPACITY = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pal_pkg::dp_cmd_type  cmd,
   output pal_pkg::dp_stat_type      stat,
   input  wire logic [1:0]           req_operation,
   input  wire logic [5:0]           req_position,
   input  wire logic signed [31:0]   req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [2:0]                rsp_status,
   output logic signed [31:0]        rsp_removed_value,
   output logic [4:0]                rsp_found_index,
   output logic [5:0]                rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > 6) ? CW : 6) + 1;

   pal_pkg::op_type     op_ff;
   logic [5:0]          pos_ff;
   logic signed [31:0]  val_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [31:0]         removed_ff;
   logic [AW-1:0]       index_ff;
   pal_pkg::status_type status_ff;
   logic [31:0]         rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic [31:0]         wr_data;
   logic [31:0]         mem [CAPACITY];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff;
   logic [31:0]         rsp_removed_ff;
   logic [4:0]          rsp_index_ff;
   logic [5:0]          rsp_count_ff;

   logic [EW-1:0]       pos_ext, cnt_ext, ptr_ext;

   assign pos_ext = EW'(pos_ff);
   assign cnt_ext = EW'(count_ff);
   assign ptr_ext = EW'(ptr_ff);

   // Request capture; the result fields start from their defaults.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= pal_pkg::op_type'(req_operation);
         pos_ff     <= req_position;
         val_ff     <= req_value;
         removed_ff <= '0;
         index_ff   <= '0;
         status_ff  <= pal_pkg::ST_OK;
      end else begin
         if (cmd.cap_removed) begin
            removed_ff <= rd_data_ff;
         end
         if (cmd.set_index) begin
            index_ff <= ptr_ff[AW-1:0];
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_from_count) begin
         ptr_in = count_ff;
      end else if (cmd.ptr_from_pos) begin
         ptr_in = CW'(pos_ext - EW'(1));
      end else if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CW'(1);
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   always_comb begin
      case (cmd.rd_sel)
         pal_pkg::RD_PREV: rd_addr = AW'(ptr_ff - CW'(1));
         pal_pkg::RD_NEXT: rd_addr = AW'(ptr_ff + CW'(1));
         default:          rd_addr = ptr_ff[AW-1:0];
      endcase
   end

   assign wr_data = cmd.wr_from_val ? val_ff : rd_data_ff;

   // List store: one write port at the pointer, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[ptr_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Result register.
   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_index_ff   <= 5'(index_ff);
         rsp_count_ff   <= 6'(count_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_found_index   = rsp_index_ff;
   assign rsp_count         = rsp_count_ff;

   always_comb begin
      stat.op           = op_ff;
      stat.full         = (count_ff == CW'(CAPACITY));
      stat.empty        = (count_ff == '0);
      stat.ins_pos_bad  = (pos_ff == '0) || (pos_ext > cnt_ext + EW'(1));
      stat.del_pos_bad  = (pos_ff == '0) || (pos_ext > cnt_ext);
      stat.ins_ptr_done = (ptr_ext == pos_ext - EW'(1));
      stat.del_ptr_done = (ptr_ext + EW'(1) >= cnt_ext);
      stat.scan_done    = (ptr_ff >= count_ff);
      stat.hit          = (rd_data_ff == val_ff);
      stat.rsp_free     = ~rsp_valid_ff | ~rsp_stall;
   end

endmodule

`default_nettype wire

[hw/rtl/pal_ctrl.sv]
// Controller of the positional array list: the state machine that sequences
// decode, entry moves, search and result hand-off. Depends on pal_pkg.
`default_nettype none

module pal_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire pal_pkg::dp_stat_type stat,
   output pal_pkg::dp_cmd_type       cmd,
   output logic                      idle
);

   pal_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pal_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = pal_pkg::RD_CUR;
      cmd.status_code = pal_pkg::ST_OK;
      idle            = 1'b0;
      case (state_ff)
         pal_pkg::S_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = pal_pkg::S_DECODE;
            end
         end
         pal_pkg::S_DECODE: begin
            case (stat.op)
               pal_pkg::OP_CLEAR: begin
                  cmd.count_clear = 1'b1;
                  state_in        = pal_pkg::S_FINISH;
               end
               pal_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = pal_pkg::ST_FULL;
                     state_in        = pal_pkg::S_FINISH;
                  end else if (stat.ins_pos_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = pal_pkg::ST_BADPOS;
                     state_in        = pal_pkg::S_FINISH;
                  end else begin
                     cmd.ptr_from_count = 1'b1;
                     state_in           = pal_pkg::S_INS_RD;
                  end
               end
               pal_pkg::OP_DELETE: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = pal_pkg::ST_EMPTY;
                     state_in        = pal_pkg::S_FINISH;
                  end else if (stat.del_pos_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = pal_pkg::ST_BADPOS;
                     state_in        = pal_pkg::S_FINISH;
                  end else begin
                     cmd.ptr_from_pos = 1'b1;
                     state_in         = pal_pkg::S_DEL_RD;
                  end
               end
               default: begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = pal_pkg::S_LOC_RD;
               end
            endcase
         end
         pal_pkg::S_INS_RD: begin
            if (stat.ins_ptr_done) begin
               cmd.mem_we      = 1'b1;
               cmd.wr_from_val = 1'b1;
               cmd.count_inc   = 1'b1;
               state_in        = pal_pkg::S_FINISH;
            end else begin
               cmd.rd_sel = pal_pkg::RD_PREV;
               state_in   = pal_pkg::S_INS_WR;
            end
         end
         pal_pkg::S_INS_WR: begin
            cmd.mem_we  = 1'b1;
            cmd.ptr_dec = 1'b1;
            state_in    = pal_pkg::S_INS_RD;
         end
         pal_pkg::S_DEL_RD: begin
            cmd.rd_sel = pal_pkg::RD_CUR;
            state_in   = pal_pkg::S_DEL_CAP;
         end
         pal_pkg::S_DEL_CAP: begin
            cmd.cap_removed = 1'b1;
            state_in        = pal_pkg::S_DEL_MRD;
         end
         pal_pkg::S_DEL_MRD: begin
            if (stat.del_ptr_done) begin
               cmd.count_dec = 1'b1;
               state_in      = pal_pkg::S_FINISH;
            end else begin
               cmd.rd_sel = pal_pkg::RD_NEXT;
               state_in   = pal_pkg::S_DEL_MWR;
            end
         end
         pal_pkg::S_DEL_MWR: begin
            cmd.mem_we  = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = pal_pkg::S_DEL_MRD;
         end
         pal_pkg::S_LOC_RD: begin
            if (stat.scan_done) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = pal_pkg::ST_NOTFOUND;
               state_in        = pal_pkg::S_FINISH;
            end else begin
               cmd.rd_sel = pal_pkg::RD_CUR;
               state_in   = pal_pkg::S_LOC_CMP;
            end
         end
         pal_pkg::S_LOC_CMP: begin
            if (stat.hit) begin
               cmd.set_index = 1'b1;
               state_in      = pal_pkg::S_FINISH;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = pal_pkg::S_LOC_RD;
            end
         end
         pal_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = pal_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pal_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/positional_array_list.sv]
// Positional array list: a bounded ordered list of signed 32-bit values.
// Each request transfer carries an operation (clear, insert, delete, locate), a 1-based
// position and a value; each one yields exactly one response transfer with a status,
// the removed value, the found index and the entry count after the operation.
// Both channels use valid and stall: a transfer happens at a rising edge with valid high
// and stall low. The block takes one request at a time; req_stall is low only while
// the controller is idle.
// Each operation passes decode and ends in a finish state that loads the response register.
// Insert moves each entry from position p upward by one and then writes the value; delete
// reads and captures the entry at p, then moves each later entry down by one; locate reads
// and compares the entries in order from the first until a match or the end of the list.
// The list store's registered read port makes each entry move or compare a read state
// followed by a write or compare state, and the controller returns to idle before the
// next request transfer.
// Reset (synchronous, active high) empties the list and drops any pending response;
// the stored values are not cleared and are never read before being written.
// When the receiver stalls, the response stays registered and unchanged; a finished
// operation waits in its last state until the response register frees up.
`default_nettype none

module positional_array_list #(
   parameter int CAPACITY = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic [5:0]         req_position,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_removed_value,
   output logic [4:0]              rsp_found_index,
   output logic [5:0]              rsp_count
);

   pal_pkg::dp_cmd_type  cmd;
   pal_pkg::dp_stat_type stat;
   logic                 idle;

   // The controller sequences each operation; the datapath holds all storage.
   pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   pal_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found_index   (rsp_found_index),
      .rsp_count         (rsp_count)
   );

   // A new request is taken only while the controller waits in idle.
   assign req_stall = ~idle;

endmodule

`default_nettype wire

[hw/rtl/pal_checker.sv]
// Port-level checks for the positional array list, attached to the top level by bind.
// Depends on pal_pkg for the status codes.
`default_nettype none

module pal_checker #(
   parameter int CAPACITY = 32
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [2:0]         rsp_status,
   input wire logic signed [31:0] rsp_removed_value,
   input wire logic [4:0]         rsp_found_index,
   input wire logic [5:0]         rsp_count
);

   // A stalled response keeps its whole payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_value) && $stable(rsp_found_index) && $stable(rsp_count))
      else $error("stalled response changed");

   // Once a request is taken, the block is busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

   // Full is only reported with the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pal_pkg::ST_FULL) |-> rsp_count == 6'(CAPACITY))
      else $error("full status with list below capacity");

   // Empty is only reported with no entries.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pal_pkg::ST_EMPTY) |-> rsp_count == '0)
      else $error("empty status with entries present");

   // Failed operations return zero in the removed value and index fields.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pal_pkg::ST_OK) |->
         rsp_removed_value == '0 && rsp_found_index == '0)
      else $error("failed operation returned data");

endmodule

bind positional_array_list pal_checker #(
   .CAPACITY (CAPACITY)
) u_pal_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_found_index   (rsp_found_index),
   .rsp_count         (rsp_count)
);

`default_nettype wire
